>>> sv/fprs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight phase ramp sequencer package
// Shared types, codes and register map for the sequencer block.
// ----------------------------------------------------------------------------
package fprs_pkg;

   localparam int DUR_W      = 16;
   localparam int TGT_W      = 8;
   localparam int LEVEL_W    = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [TGT_W-1:0] RST_OFFSET_TARGET  = 8'd130;
   localparam logic [TGT_W-1:0] RST_AMP_TARGET     = 8'd140;
   localparam logic [DUR_W-1:0] RST_OFFSET_RAMP_MS = 16'd2000;
   localparam logic [DUR_W-1:0] RST_AMP_RAMP_MS    = 16'd2000;
   localparam logic [DUR_W-1:0] RST_LIFTOFF_MS     = 16'd100;
   localparam logic [DUR_W-1:0] RST_LAND_MS        = 16'd500;
   localparam logic [DUR_W-1:0] RST_RESET_MS       = 16'd1000;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_START = 2'd1,
      CMD_END   = 2'd2
   } command_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_OFS_UP   = 4'd1,
      PH_AMP_UP   = 4'd2,
      PH_LIFTOFF  = 4'd3,
      PH_CTRL_ON  = 4'd4,
      PH_LAND     = 4'd5,
      PH_AMP_DOWN = 4'd6,
      PH_OFS_DOWN = 4'd7,
      PH_RESET    = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      NOTE_NONE    = 3'd0,
      NOTE_IDLE    = 3'd1,
      NOTE_LIFTOFF = 3'd2,
      NOTE_CTRL_ON = 3'd3,
      NOTE_LAND    = 3'd4,
      NOTE_RESET   = 3'd5
   } note_type;

   typedef enum logic [2:0] {
      REG_OFFSET_TARGET  = 3'd0,
      REG_AMP_TARGET     = 3'd1,
      REG_OFFSET_RAMP_MS = 3'd2,
      REG_AMP_RAMP_MS    = 3'd3,
      REG_LIFTOFF_MS     = 3'd4,
      REG_LAND_MS        = 3'd5,
      REG_RESET_MS       = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] elapsed_ms;
   } req_word_type;

   typedef struct packed {
      logic [3:0]         phase;
      logic               frame_valid;
      logic [LEVEL_W-1:0] offset_level;
      logic [LEVEL_W-1:0] amplitude_level;
      logic [2:0]         mode_notice;
      logic               bias_on;
   } rsp_word_type;

   typedef struct packed {
      logic [TGT_W-1:0] offset_target;
      logic [TGT_W-1:0] amp_target;
      logic [DUR_W-1:0] offset_ramp_ms;
      logic [DUR_W-1:0] amp_ramp_ms;
      logic [DUR_W-1:0] liftoff_ms;
      logic [DUR_W-1:0] land_ms;
      logic [DUR_W-1:0] reset_ms;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic start_mul;
      logic div_step;
      logic publish;
   } dp_cmd_type;

   typedef struct packed {
      logic need_ramp;
      logic div_done;
      logic out_free;
   } dp_stat_type;

endpackage

>>> sv/fprs_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight phase ramp sequencer configuration registers
// APB-style register file holding ramp targets and phase durations.
// ----------------------------------------------------------------------------
module fprs_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [fprs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [fprs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [fprs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output fprs_pkg::cfg_type                cfg
);
   import fprs_pkg::*;

   cfg_type       cfg_ff;
   logic          wr_en;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = reg_index_type'(csr_paddr[4:2]);
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_target  <= RST_OFFSET_TARGET;
         cfg_ff.amp_target     <= RST_AMP_TARGET;
         cfg_ff.offset_ramp_ms <= RST_OFFSET_RAMP_MS;
         cfg_ff.amp_ramp_ms    <= RST_AMP_RAMP_MS;
         cfg_ff.liftoff_ms     <= RST_LIFTOFF_MS;
         cfg_ff.land_ms        <= RST_LAND_MS;
         cfg_ff.reset_ms       <= RST_RESET_MS;
      end else if (wr_en) begin
         unique case (idx)
            REG_OFFSET_TARGET:  cfg_ff.offset_target  <= csr_pwdata[TGT_W-1:0];
            REG_AMP_TARGET:     cfg_ff.amp_target     <= csr_pwdata[TGT_W-1:0];
            REG_OFFSET_RAMP_MS: cfg_ff.offset_ramp_ms <= csr_pwdata[DUR_W-1:0];
            REG_AMP_RAMP_MS:    cfg_ff.amp_ramp_ms    <= csr_pwdata[DUR_W-1:0];
            REG_LIFTOFF_MS:     cfg_ff.liftoff_ms     <= csr_pwdata[DUR_W-1:0];
            REG_LAND_MS:        cfg_ff.land_ms        <= csr_pwdata[DUR_W-1:0];
            REG_RESET_MS:       cfg_ff.reset_ms       <= csr_pwdata[DUR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_OFFSET_TARGET:  csr_prdata = CSR_DATA_W'(cfg_ff.offset_target);
         REG_AMP_TARGET:     csr_prdata = CSR_DATA_W'(cfg_ff.amp_target);
         REG_OFFSET_RAMP_MS: csr_prdata = CSR_DATA_W'(cfg_ff.offset_ramp_ms);
         REG_AMP_RAMP_MS:    csr_prdata = CSR_DATA_W'(cfg_ff.amp_ramp_ms);
         REG_LIFTOFF_MS:     csr_prdata = CSR_DATA_W'(cfg_ff.liftoff_ms);
         REG_LAND_MS:        csr_prdata = CSR_DATA_W'(cfg_ff.land_ms);
         REG_RESET_MS:       csr_prdata = CSR_DATA_W'(cfg_ff.reset_ms);
         default:            csr_prdata = '0;
      endcase
   end

endmodule

>>> sv/fprs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight phase ramp sequencer controller
// Sequences load, multiply and serial divide (ramp ticks only) and publish of one tick word.
// ----------------------------------------------------------------------------
module fprs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fprs_pkg::dp_stat_type stat,
   output fprs_pkg::dp_cmd_type  cmd
);
   import fprs_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_PUB
   } state_type;

   state_type state_ff;
   logic      stall_ff;

   assign req_stall = stall_ff;

   always_comb begin
      cmd.load      = (state_ff == S_IDLE) && req_valid;
      cmd.start_mul = (state_ff == S_MUL);
      cmd.div_step  = (state_ff == S_DIV);
      cmd.publish   = (state_ff == S_PUB) && stat.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stall_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  stall_ff <= 1'b1;
                  state_ff <= stat.need_ramp ? S_MUL : S_PUB;
               end
            end
            S_MUL: state_ff <= S_DIV;
            S_DIV: begin
               if (stat.div_done) state_ff <= S_PUB;
            end
            S_PUB: begin
               if (stat.out_free) begin
                  state_ff <= S_IDLE;
                  stall_ff <= 1'b0;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> stall_ff)
      else $error("controller busy without stall");

   a_load_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff != S_IDLE))
      else $error("load did not start a step");

   a_div_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && !stat.div_done) |=> (state_ff == S_DIV))
      else $error("divide left early");

   a_publish_in_pub: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> (state_ff == S_IDLE))
      else $error("publish did not return to idle");

endmodule

>>> sv/fprs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight phase ramp sequencer datapath
// Phase and timer update, ramp level multiply and serial divide, output word.
// ----------------------------------------------------------------------------
module fprs_dp #(
   parameter int TIMER_BITS    = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fprs_pkg::cfg_type      cfg,
   input  fprs_pkg::req_word_type req_data,
   input  fprs_pkg::dp_cmd_type   cmd,
   output fprs_pkg::dp_stat_type  stat,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fprs_pkg::rsp_word_type rsp_data
);
   import fprs_pkg::*;

   localparam int CMP_W  = (TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W;
   localparam int FULL_W = TGT_W + FRACTION_BITS;
   localparam int NUM_W  = FULL_W + DUR_W;
   localparam int CNT_W  = $clog2(NUM_W + 1);

   phase_type             phase_ff;
   logic [TIMER_BITS-1:0] timer_ff;
   logic                  bias_ff;
   logic [LEVEL_W-1:0]    ofs_hold_ff;
   logic [LEVEL_W-1:0]    amp_hold_ff;
   note_type              note_ff;
   logic                  frame_ff;
   logic                  sel_amp_ff;
   logic [DUR_W-1:0]      den_ff;
   logic [DUR_W-1:0]      num_ff;
   logic [FULL_W-1:0]     full_ff;
   logic [NUM_W-1:0]      quo_ff;
   logic [DUR_W-1:0]      rem_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_ff;

   logic [TIMER_BITS:0]   t_sum;
   logic [TIMER_BITS-1:0] t_sat;
   logic [TIMER_BITS-1:0] t_now;
   logic [CMP_W-1:0]      t_cmp;
   logic [TIMER_BITS-1:0] timer_in;
   phase_type             ph_cmd;
   phase_type             phase_in;
   note_type              note_in;
   logic                  bias_in;
   logic                  cmd_hit;
   logic                  ramp;
   logic                  down;
   logic                  sel_amp;
   logic [DUR_W-1:0]      lim;
   logic [TGT_W-1:0]      target;
   logic [DUR_W-1:0]      num_in;
   logic [DUR_W:0]        rem_sh;
   logic                  ge;
   logic [LEVEL_W-1:0]    level;
   logic [LEVEL_W-1:0]    ofs_new;
   logic [LEVEL_W-1:0]    amp_new;

   always_comb begin
      t_sum    = {1'b0, timer_ff} + (TIMER_BITS + 1)'(req_data.elapsed_ms);
      t_sat    = t_sum[TIMER_BITS] ? '1 : t_sum[TIMER_BITS-1:0];
      ph_cmd   = phase_ff;
      bias_in  = bias_ff;
      note_in  = NOTE_NONE;
      cmd_hit  = 1'b0;
      if (req_data.command == CMD_START && phase_ff == PH_IDLE) begin
         ph_cmd  = PH_OFS_UP;
         bias_in = 1'b1;
         cmd_hit = 1'b1;
      end else if (req_data.command == CMD_END && phase_ff == PH_CTRL_ON) begin
         ph_cmd  = PH_LAND;
         note_in = NOTE_LAND;
         cmd_hit = 1'b1;
      end
      t_now    = cmd_hit ? '0 : t_sat;
      t_cmp    = CMP_W'(t_now);
      phase_in = ph_cmd;
      ramp     = 1'b0;
      down     = 1'b0;
      sel_amp  = 1'b0;
      lim      = cfg.offset_ramp_ms;
      target   = cfg.offset_target;
      unique case (ph_cmd)
         PH_OFS_UP: begin
            if (t_cmp >= CMP_W'(lim)) begin
               phase_in = PH_AMP_UP;
               note_in  = NOTE_IDLE;
            end else ramp = 1'b1;
         end
         PH_AMP_UP: begin
            lim     = cfg.amp_ramp_ms;
            target  = cfg.amp_target;
            sel_amp = 1'b1;
            if (t_cmp >= CMP_W'(lim)) begin
               phase_in = PH_LIFTOFF;
               note_in  = NOTE_LIFTOFF;
            end else ramp = 1'b1;
         end
         PH_LIFTOFF: begin
            lim = cfg.liftoff_ms;
            if (t_cmp >= CMP_W'(lim)) begin
               phase_in = PH_CTRL_ON;
               note_in  = NOTE_CTRL_ON;
            end
         end
         PH_LAND: begin
            lim = cfg.land_ms;
            if (t_cmp >= CMP_W'(lim)) begin
               phase_in = PH_AMP_DOWN;
               note_in  = NOTE_RESET;
            end
         end
         PH_AMP_DOWN: begin
            lim     = cfg.amp_ramp_ms;
            target  = cfg.amp_target;
            sel_amp = 1'b1;
            down    = 1'b1;
            if (t_cmp >= CMP_W'(lim)) begin
               phase_in = PH_OFS_DOWN;
               bias_in  = 1'b0;
            end else ramp = 1'b1;
         end
         PH_OFS_DOWN: begin
            down = 1'b1;
            if (t_cmp >= CMP_W'(lim)) phase_in = PH_RESET;
            else ramp = 1'b1;
         end
         PH_RESET: begin
            lim = cfg.reset_ms;
            if (t_cmp >= CMP_W'(lim)) phase_in = PH_IDLE;
         end
         default: ;
      endcase
      timer_in = (phase_in != ph_cmd) ? '0 : t_now;
      num_in   = down ? (lim - t_cmp[DUR_W-1:0]) : t_cmp[DUR_W-1:0];
   end

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      level   = quo_ff[LEVEL_W-1:0];
      ofs_new = (frame_ff && !sel_amp_ff) ? level : ofs_hold_ff;
      amp_new = (frame_ff && sel_amp_ff) ? level : amp_hold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         timer_ff     <= '0;
         bias_ff      <= 1'b0;
         ofs_hold_ff  <= '0;
         amp_hold_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            phase_ff <= phase_in;
            timer_ff <= timer_in;
            bias_ff  <= bias_in;
         end
         if (cmd.publish) begin
            ofs_hold_ff  <= ofs_new;
            amp_hold_ff  <= amp_new;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         note_ff    <= note_in;
         frame_ff   <= ramp;
         sel_amp_ff <= sel_amp;
         den_ff     <= lim;
         num_ff     <= num_in;
         full_ff    <= FULL_W'(target) << FRACTION_BITS;
      end
      if (cmd.start_mul) begin
         quo_ff <= NUM_W'(full_ff) * NUM_W'(num_ff);
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
         rem_ff <= ge ? DUR_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DUR_W-1:0];
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.publish) begin
         rsp_ff.phase           <= phase_ff;
         rsp_ff.frame_valid     <= frame_ff;
         rsp_ff.offset_level    <= ofs_new;
         rsp_ff.amplitude_level <= amp_new;
         rsp_ff.mode_notice     <= note_ff;
         rsp_ff.bias_on         <= bias_ff;
      end
   end

   assign stat.need_ramp = ramp;
   assign stat.div_done  = (cnt_ff == CNT_W'(NUM_W - 1));
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_ff;

   a_bias_span: assert property (@(posedge clock) disable iff (reset)
      bias_ff == (phase_ff >= PH_OFS_UP && phase_ff <= PH_AMP_DOWN))
      else $error("bias out of step with phase");

   a_frame_in_ramp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.frame_valid) |->
      (rsp_ff.phase == PH_OFS_UP || rsp_ff.phase == PH_AMP_UP ||
       rsp_ff.phase == PH_AMP_DOWN || rsp_ff.phase == PH_OFS_DOWN))
      else $error("frame sent outside a ramp phase");

   a_quotient_fits: assert property (@(posedge clock) disable iff (reset)
      (cmd.publish && frame_ff) |-> (quo_ff <= NUM_W'(full_ff)))
      else $error("ramp level above target");

endmodule

>>> sv/flight_phase_ramp_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight phase ramp sequencer
// Tick-driven flight phase sequencer with offset and amplitude ramps.
// ----------------------------------------------------------------------------
// Flow: a tick without a ramp frame goes from load straight to publish; a ramp
//   tick passes load, multiply, the one-bit-per-cycle level divider and publish.
// A new tick is taken only after the previous word is published, and publish
//   waits while a held response word is stalled.
// Reset: synchronous; phase idle, timer, levels and bias cleared, registers
//   back to their defaults.
module flight_phase_ramp_sequencer_unit #(
   parameter int TIMER_BITS    = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  fprs_pkg::req_word_type           req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output fprs_pkg::rsp_word_type           rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [fprs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [fprs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [fprs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import fprs_pkg::*;

   cfg_type     cfg;
   dp_cmd_type  cmd;
   dp_stat_type stat;

   fprs_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fprs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   fprs_dp #(
      .TIMER_BITS    (TIMER_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> verif/flight_phase_ramp_sequencer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight phase ramp sequencer testbench
// Drives control ticks through the sequencer under several register settings.
// Each response word is checked against a phase-by-phase model of the flight
// sequence. The run opens with a directed table and follows with random
// flights under random idling on both sides.
// ----------------------------------------------------------------------------
module flight_phase_ramp_sequencer_unit_test;
   import fprs_pkg::*;

   localparam int FRAC_BITS       = 8;
   localparam int STALL_LIMIT     = 4000;
   localparam int LONG_HOLD       = 400;
   localparam int DRAIN_CYCLES    = 40;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam cfg_type DEFAULT_CFG = '{
      offset_target:  RST_OFFSET_TARGET,
      amp_target:     RST_AMP_TARGET,
      offset_ramp_ms: RST_OFFSET_RAMP_MS,
      amp_ramp_ms:    RST_AMP_RAMP_MS,
      liftoff_ms:     RST_LIFTOFF_MS,
      land_ms:        RST_LAND_MS,
      reset_ms:       RST_RESET_MS
   };

   localparam rsp_word_type QUIET_IDLE = '{
      phase: PH_IDLE, frame_valid: 1'b0, offset_level: 16'd0,
      amplitude_level: 16'd0, mode_notice: NOTE_NONE, bias_on: 1'b0
   };
   localparam rsp_word_type FIRST_RAMP_FRAME = '{
      phase: PH_OFS_UP, frame_valid: 1'b1, offset_level: 16'd0,
      amplitude_level: 16'd0, mode_notice: NOTE_NONE, bias_on: 1'b1
   };

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      req_word_type  word;
      bit            typed;
      rsp_word_type  rsp;
      reg_index_type idx;
      logic [31:0]   value;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // flight model state
   phase_type    flight_phase = PH_IDLE;
   logic [15:0]  phase_ms = '0;
   logic [15:0]  offset_hold_q = '0;
   logic [15:0]  amp_hold_q = '0;
   logic         bias_q = 1'b0;
   cfg_type      flight_cfg = DEFAULT_CFG;

   rsp_word_type flight_expect_q[$];
   plan_row_type plan_q[$];

   int mismatch_count = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int hold_left = 0;
   int seg_left = 0;
   int stall_mode = 0;
   bit long_hold = 1'b0;

   flight_phase_ramp_sequencer_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [15:0] ramp_point(logic [7:0] tgt, logic [15:0] num,
                                              logic [15:0] den);
      logic [63:0] scaled;
      scaled = ({56'd0, tgt} << FRAC_BITS) * {48'd0, num};
      return 16'(scaled / {48'd0, den});
   endfunction

   function automatic rsp_word_type step_flight(req_word_type w);
      rsp_word_type r;
      note_type     note;
      logic         frame;
      logic [16:0]  sum;
      note  = NOTE_NONE;
      frame = 1'b0;
      sum = {1'b0, phase_ms} + 17'(w.elapsed_ms);
      phase_ms = sum[16] ? 16'hFFFF : sum[15:0];
      if (w.command == CMD_START && flight_phase == PH_IDLE) begin
         flight_phase = PH_OFS_UP;
         phase_ms = '0;
         bias_q = 1'b1;
      end else if (w.command == CMD_END && flight_phase == PH_CTRL_ON) begin
         flight_phase = PH_LAND;
         phase_ms = '0;
         note = NOTE_LAND;
      end
      case (flight_phase)
         PH_OFS_UP: begin
            if (phase_ms >= flight_cfg.offset_ramp_ms) begin
               flight_phase = PH_AMP_UP;
               phase_ms = '0;
               note = NOTE_IDLE;
            end else begin
               offset_hold_q = ramp_point(flight_cfg.offset_target, phase_ms,
                                          flight_cfg.offset_ramp_ms);
               frame = 1'b1;
            end
         end
         PH_AMP_UP: begin
            if (phase_ms >= flight_cfg.amp_ramp_ms) begin
               flight_phase = PH_LIFTOFF;
               phase_ms = '0;
               note = NOTE_LIFTOFF;
            end else begin
               amp_hold_q = ramp_point(flight_cfg.amp_target, phase_ms,
                                       flight_cfg.amp_ramp_ms);
               frame = 1'b1;
            end
         end
         PH_LIFTOFF: begin
            if (phase_ms >= flight_cfg.liftoff_ms) begin
               flight_phase = PH_CTRL_ON;
               phase_ms = '0;
               note = NOTE_CTRL_ON;
            end
         end
         PH_LAND: begin
            if (phase_ms >= flight_cfg.land_ms) begin
               flight_phase = PH_AMP_DOWN;
               phase_ms = '0;
               note = NOTE_RESET;
            end
         end
         PH_AMP_DOWN: begin
            if (phase_ms >= flight_cfg.amp_ramp_ms) begin
               flight_phase = PH_OFS_DOWN;
               phase_ms = '0;
               bias_q = 1'b0;
            end else begin
               amp_hold_q = ramp_point(flight_cfg.amp_target,
                                       flight_cfg.amp_ramp_ms - phase_ms,
                                       flight_cfg.amp_ramp_ms);
               frame = 1'b1;
            end
         end
         PH_OFS_DOWN: begin
            if (phase_ms >= flight_cfg.offset_ramp_ms) begin
               flight_phase = PH_RESET;
               phase_ms = '0;
            end else begin
               offset_hold_q = ramp_point(flight_cfg.offset_target,
                                          flight_cfg.offset_ramp_ms - phase_ms,
                                          flight_cfg.offset_ramp_ms);
               frame = 1'b1;
            end
         end
         PH_RESET: begin
            if (phase_ms >= flight_cfg.reset_ms) begin
               flight_phase = PH_IDLE;
               phase_ms = '0;
            end
         end
         default: begin
         end
      endcase
      r.phase           = flight_phase;
      r.frame_valid     = frame;
      r.offset_level    = offset_hold_q;
      r.amplitude_level = amp_hold_q;
      r.mode_notice     = note;
      r.bias_on         = bias_q;
      return r;
   endfunction

   function automatic logic [31:0] cfg_field(cfg_type c, reg_index_type idx);
      case (idx)
         REG_OFFSET_TARGET:  return 32'(c.offset_target);
         REG_AMP_TARGET:     return 32'(c.amp_target);
         REG_OFFSET_RAMP_MS: return 32'(c.offset_ramp_ms);
         REG_AMP_RAMP_MS:    return 32'(c.amp_ramp_ms);
         REG_LIFTOFF_MS:     return 32'(c.liftoff_ms);
         REG_LAND_MS:        return 32'(c.land_ms);
         REG_RESET_MS:       return 32'(c.reset_ms);
         default:            return '0;
      endcase
   endfunction

   function automatic logic [7:0] pick_elapsed(bit high_bias);
      if (high_bias && $urandom_range(0, 7) != 0)
         return 8'hFF;
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'hFF;
         2:       return 8'($urandom_range(0, 3));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [15:0] mixed_duration();
      case ($urandom_range(0, 5))
         0:       return 16'd0;
         1:       return 16'd1;
         2:       return 16'hFFFF;
         default: return 16'($urandom_range(2, 1500));
      endcase
   endfunction

   task automatic check_value(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch %s: expected %0h, got %0h", what, want, got);
      end
   endtask

   task automatic csr_access(input reg_index_type idx, input bit wr,
                             input logic [31:0] value, output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(idx));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_register(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] unused;
      csr_access(idx, 1'b1, value, unused);
      case (idx)
         REG_OFFSET_TARGET:  flight_cfg.offset_target  = value[7:0];
         REG_AMP_TARGET:     flight_cfg.amp_target     = value[7:0];
         REG_OFFSET_RAMP_MS: flight_cfg.offset_ramp_ms = value[15:0];
         REG_AMP_RAMP_MS:    flight_cfg.amp_ramp_ms    = value[15:0];
         REG_LIFTOFF_MS:     flight_cfg.liftoff_ms     = value[15:0];
         REG_LAND_MS:        flight_cfg.land_ms        = value[15:0];
         REG_RESET_MS:       flight_cfg.reset_ms       = value[15:0];
         default: begin
         end
      endcase
   endtask

   task automatic read_back_settings();
      logic [31:0]   got;
      reg_index_type idx;
      for (int i = 0; i <= int'(REG_RESET_MS); i++) begin
         idx = reg_index_type'(i);
         csr_access(idx, 1'b0, '0, got);
         check_value($sformatf("csr %0d", i), cfg_field(flight_cfg, idx), got);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      wait (flight_expect_q.size() == 0);
   endtask

   task automatic apply_settings(input cfg_type c);
      wait_drained();
      for (int i = 0; i <= int'(REG_RESET_MS); i++)
         program_register(reg_index_type'(i), cfg_field(c, reg_index_type'(i)));
      read_back_settings();
   endtask

   task automatic send_tick(input req_word_type w, input bit typed,
                            input rsp_word_type typed_rsp);
      int           gap;
      rsp_word_type want;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 24);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = step_flight(w);
      flight_expect_q.push_back(typed ? typed_rsp : want);
      burst_left--;
   endtask

   task automatic run_phase(input cfg_type c, input int count, input bit high_bias);
      req_word_type w;
      apply_settings(c);
      repeat (count) begin
         if ($urandom_range(0, 11) == 0)
            w.command = 2'($urandom_range(0, 3));
         else if (flight_phase == PH_IDLE && $urandom_range(0, 2) == 0)
            w.command = CMD_START;
         else if (flight_phase == PH_CTRL_ON && $urandom_range(0, 3) == 0)
            w.command = CMD_END;
         else
            w.command = CMD_NONE;
         w.elapsed_ms = pick_elapsed(high_bias);
         send_tick(w, 1'b0, '0);
      end
   endtask

   task automatic plan_tick(input logic [1:0] cmd, input logic [7:0] ms);
      plan_row_type row;
      row.kind = ROW_TICK;
      row.word = '{command: cmd, elapsed_ms: ms};
      row.typed = 1'b0;
      row.rsp = '0;
      plan_q.push_back(row);
   endtask

   task automatic plan_typed(input logic [1:0] cmd, input logic [7:0] ms,
                             input rsp_word_type rsp);
      plan_row_type row;
      row.kind = ROW_TICK;
      row.word = '{command: cmd, elapsed_ms: ms};
      row.typed = 1'b1;
      row.rsp = rsp;
      plan_q.push_back(row);
   endtask

   task automatic plan_write(input reg_index_type idx, input logic [31:0] value);
      plan_row_type row;
      row.kind = ROW_WRITE;
      row.idx = idx;
      row.value = value;
      plan_q.push_back(row);
   endtask

   // response side stall pattern
   always @(posedge clock) begin
      logic next_stall;
      if (long_hold) begin
         long_hold = 1'b0;
         hold_left = LONG_HOLD;
      end
      if (seg_left == 0) begin
         seg_left = $urandom_range(10, 150);
         stall_mode = $urandom_range(0, 2);
      end
      seg_left--;
      if (hold_left > 0) begin
         hold_left--;
         next_stall = 1'b1;
      end else begin
         case (stall_mode)
            0:       next_stall = 1'b0;
            1:       next_stall = ($urandom_range(0, 3) == 0);
            default: next_stall = ($urandom_range(0, 9) < 7);
         endcase
      end
      rsp_stall <= reset ? 1'b0 : next_stall;
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (flight_expect_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: unexpected response word %h", rsp_data);
         end else begin
            want = flight_expect_q.pop_front();
            check_value("phase", 32'(want.phase), 32'(rsp_data.phase));
            check_value("frame_valid", 32'(want.frame_valid), 32'(rsp_data.frame_valid));
            check_value("offset_level", 32'(want.offset_level),
                        32'(rsp_data.offset_level));
            check_value("amplitude_level", 32'(want.amplitude_level),
                        32'(rsp_data.amplitude_level));
            check_value("mode_notice", 32'(want.mode_notice), 32'(rsp_data.mode_notice));
            check_value("bias_on", 32'(want.bias_on), 32'(rsp_data.bias_on));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("flight_phase_ramp_sequencer_unit regression: fail");
         $finish;
      end
   end

   initial begin
      cfg_type c;

      // defaults: noise in idle, start, stray commands in a ramp
      plan_typed(CMD_NONE, 8'd0, QUIET_IDLE);
      plan_typed(CMD_UNUSED, 8'd255, QUIET_IDLE);
      plan_typed(CMD_END, 8'd255, QUIET_IDLE);
      plan_typed(CMD_START, 8'd0, FIRST_RAMP_FRAME);
      plan_tick(CMD_START, 8'd255);
      plan_tick(CMD_END, 8'd255);
      // zero durations: pass through every phase without frames
      plan_write(REG_OFFSET_TARGET, 32'd255);
      plan_write(REG_AMP_TARGET, 32'd255);
      plan_write(REG_OFFSET_RAMP_MS, 32'd0);
      plan_write(REG_AMP_RAMP_MS, 32'd0);
      plan_write(REG_LIFTOFF_MS, 32'd0);
      plan_write(REG_LAND_MS, 32'd0);
      plan_write(REG_RESET_MS, 32'd0);
      plan_tick(CMD_NONE, 8'd0);
      plan_tick(CMD_NONE, 8'd0);
      plan_tick(CMD_NONE, 8'd255);
      plan_tick(CMD_START, 8'd255);
      plan_tick(CMD_END, 8'd0);
      plan_tick(CMD_NONE, 8'd0);
      plan_tick(CMD_NONE, 8'd0);
      plan_tick(CMD_NONE, 8'd0);
      plan_tick(CMD_START, 8'd255);
      // longest and shortest durations, full-scale targets
      plan_write(REG_AMP_RAMP_MS, 32'd65535);
      plan_write(REG_OFFSET_RAMP_MS, 32'd1);
      plan_write(REG_LIFTOFF_MS, 32'd1);
      plan_write(REG_LAND_MS, 32'd1);
      plan_write(REG_RESET_MS, 32'd1);
      plan_tick(CMD_NONE, 8'd255);
      plan_tick(CMD_NONE, 8'd0);
      plan_write(REG_AMP_RAMP_MS, 32'd1);
      plan_tick(CMD_NONE, 8'd1);
      plan_tick(CMD_NONE, 8'd0);
      plan_tick(CMD_NONE, 8'd1);
      plan_tick(CMD_END, 8'd0);
      plan_tick(CMD_NONE, 8'd255);
      plan_tick(CMD_NONE, 8'd0);
      plan_tick(CMD_NONE, 8'd1);
      plan_tick(CMD_NONE, 8'd0);
      plan_tick(CMD_NONE, 8'd255);
      plan_tick(CMD_NONE, 8'd255);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      read_back_settings();

      foreach (plan_q[i]) begin
         if (plan_q[i].kind == ROW_WRITE) begin
            wait_drained();
            program_register(plan_q[i].idx, plan_q[i].value);
         end else begin
            send_tick(plan_q[i].word, plan_q[i].typed, plan_q[i].rsp);
         end
      end

      run_phase(DEFAULT_CFG, 140, 1'b0);

      c.offset_target  = 8'($urandom_range(0, 255));
      c.amp_target     = 8'($urandom_range(0, 255));
      c.offset_ramp_ms = 16'($urandom_range(1, 600));
      c.amp_ramp_ms    = 16'($urandom_range(1, 600));
      c.liftoff_ms     = 16'($urandom_range(1, 600));
      c.land_ms        = 16'($urandom_range(1, 600));
      c.reset_ms       = 16'($urandom_range(1, 600));
      long_hold = 1'b1;
      run_phase(c, 130, 1'b0);

      c = '{offset_target: 8'd0, amp_target: 8'd0, offset_ramp_ms: 16'd1,
            amp_ramp_ms: 16'd1, liftoff_ms: 16'd1, land_ms: 16'd1, reset_ms: 16'd1};
      run_phase(c, 110, 1'b0);

      // long ramps: timer must saturate to end the ramp
      c = '{offset_target: 8'hFF, amp_target: 8'hFF, offset_ramp_ms: 16'hFFFF,
            amp_ramp_ms: 16'hFFFF, liftoff_ms: 16'hFFFF, land_ms: 16'hFFFF,
            reset_ms: 16'hFFFF};
      run_phase(c, 400, 1'b1);

      c.offset_target  = 8'($urandom_range(0, 255));
      c.amp_target     = 8'($urandom_range(0, 255));
      c.offset_ramp_ms = 16'd0;
      c.amp_ramp_ms    = 16'd0;
      c.liftoff_ms     = 16'd0;
      c.land_ms        = 16'd0;
      c.reset_ms       = 16'd0;
      run_phase(c, 90, 1'b0);

      c.offset_target  = 8'($urandom_range(0, 255));
      c.amp_target     = 8'($urandom_range(0, 255));
      c.offset_ramp_ms = mixed_duration();
      c.amp_ramp_ms    = mixed_duration();
      c.liftoff_ms     = mixed_duration();
      c.land_ms        = mixed_duration();
      c.reset_ms       = mixed_duration();
      run_phase(c, 150, 1'b0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("flight_phase_ramp_sequencer_unit regression: pass");
      else
         $display("flight_phase_ramp_sequencer_unit regression: fail");
      $finish;
   end

endmodule
